@@ rtl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the scaled piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    // operation codes carried in the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // configuration register indexes
    localparam logic [0:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [0:0] CFG_GAIN        = 1'b1;

    localparam int COUNT_W = 9;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET = '0;
    localparam logic [VAL_W-1:0]   GAIN_RESET  = 32'h0001_0000;
    // -1.0 in Q16.16
    localparam logic [VAL_W-1:0]   MISS_VALUE  = 32'hFFFF_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCL_GO,
        ST_SCL_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dx;
        logic [VAL_W-1:0] mag;
        logic [VAL_W-1:0] width;
    } t_div_req;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] gain;
        logic [VAL_W-1:0] v;
    } t_scale_req;

    typedef struct packed {
        logic             saturated;
        logic             in_range;
        logic [VAL_W-1:0] value;
    } t_result;

endpackage

@@ rtl/scaled_piecewise_linear_interp.sv @@
// ----------------------------------------------------------------------------
// scaled_piecewise_linear_interp
// Breakpoint table in one RAM of (x, y) pairs; an evaluation scans the table
// one entry per cycle, then divides serially and scales by the gain.
// Load: one transfer per cycle while idle, no result. Evaluate over n points:
// scan, multiply-divide, scale, output register; the next item is taken only
// after the result is loaded into the output register; a miss skips divide
// and scale. A result waiting at the output stalls the next evaluation.
// Reset clears control state, point_count to 0 and gain to 1.0; table undefined.
// ----------------------------------------------------------------------------
module scaled_piecewise_linear_interp
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [71:0]  i_s_axis_tdata,   // point_index[7:0], x_value[39:8], y_value[71:40]
    input  logic         i_s_axis_tuser,   // operation
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [31:0]  o_m_axis_tdata,   // result_value[31:0]
    output logic [1:0]   o_m_axis_tuser    // in_range[0], saturated[1]
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = ($clog2(MAX_POINTS + 1) > COUNT_W) ? $clog2(MAX_POINTS + 1) : COUNT_W;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_count;
    logic [VAL_W-1:0]   r_gain;

    logic [VAL_W-1:0]   r_xq;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_raddr;
    logic               r_rvalid;
    logic [AW-1:0]      r_ridx;
    logic [VAL_W-1:0]   r_px;
    logic [VAL_W-1:0]   r_py;
    logic [VAL_W-1:0]   r_dx;
    logic [VAL_W-1:0]   r_mag;
    logic [VAL_W-1:0]   r_width;
    logic               r_neg;
    logic [VAL_W-1:0]   r_y0;
    logic [VAL_W-1:0]   r_v;
    t_result            r_res;
    logic               r_ovalid;
    t_result            r_out;

    logic               w_s_xfer;
    logic               w_op;
    logic [IDX_W-1:0]   w_idx;
    logic [VAL_W-1:0]   w_xin;
    logic [VAL_W-1:0]   w_yin;
    logic [NW-1:0]      w_count_ext;
    logic [NW-1:0]      w_n_eff;
    logic [NW-1:0]      w_idx_ext;
    logic [NW-1:0]      w_last;
    logic               w_few;

    logic               w_ram_we;
    logic               w_ram_re;
    logic [2*VAL_W-1:0] w_rdata;
    logic [VAL_W-1:0]   w_cx;
    logic [VAL_W-1:0]   w_cy;
    logic               w_hit;
    logic               w_scan_end;
    logic [VAL_W:0]     w_xdiff;
    logic [VAL_W:0]     w_wdiff;
    logic [VAL_W:0]     w_dy;
    logic [VAL_W:0]     w_dy_abs;
    logic [VAL_W:0]     w_vsum;

    logic               w_div_done;
    logic [VAL_W-1:0]   w_quot;
    logic               w_scl_done;
    t_result            w_scl_res;
    logic               w_out_load;
    logic               w_div_start;
    logic               w_scl_start;
    t_div_req           w_div_req;
    t_scale_req         w_scl_req;

    assign w_op  = i_s_axis_tuser;
    assign w_idx = i_s_axis_tdata[7:0];
    assign w_xin = i_s_axis_tdata[39:8];
    assign w_yin = i_s_axis_tdata[71:40];

    assign w_s_xfer    = i_s_axis_tvalid & o_s_axis_tready;
    assign w_count_ext = NW'(r_count);
    assign w_n_eff     = (w_count_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : w_count_ext;
    assign w_few       = w_n_eff < NW'(2);
    assign w_idx_ext   = NW'(w_idx);
    assign w_last      = r_n - NW'(1);

    // scan datapath: previous entry in r_px/r_py, current from the RAM
    assign w_cx = w_rdata[2*VAL_W-1:VAL_W];
    assign w_cy = w_rdata[VAL_W-1:0];
    assign w_hit = (r_state == ST_SCAN) && r_rvalid && (r_ridx != '0)
                   && ($signed(r_px) <= $signed(r_xq)) && ($signed(r_xq) < $signed(w_cx));
    assign w_scan_end = (r_state == ST_SCAN) && r_rvalid && (r_ridx == w_last[AW-1:0]);

    assign w_xdiff  = {r_xq[VAL_W-1], r_xq} - {r_px[VAL_W-1], r_px};
    assign w_wdiff  = {w_cx[VAL_W-1], w_cx} - {r_px[VAL_W-1], r_px};
    assign w_dy     = {w_cy[VAL_W-1], w_cy} - {r_py[VAL_W-1], r_py};
    assign w_dy_abs = w_dy[VAL_W] ? (~w_dy + 33'd1) : w_dy;
    // y0 + q lies between y0 and y1, so the low 32 bits are exact
    assign w_vsum   = r_neg ? ({r_y0[VAL_W-1], r_y0} - {1'b0, w_quot})
                            : ({r_y0[VAL_W-1], r_y0} + {1'b0, w_quot});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_xfer && (w_op == OP_EVAL)) begin
                    n_state = w_few ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = ST_DIV_GO;
                end else if (w_scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_SCL_GO;
                end
            end
            ST_SCL_GO:   n_state = ST_SCL_WAIT;
            ST_SCL_WAIT: begin
                if (w_scl_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_ram_re        = 1'b0;
        w_out_load      = 1'b0;
        w_div_start     = 1'b0;
        w_scl_start     = 1'b0;
        case (r_state)
            ST_IDLE:   o_s_axis_tready = 1'b1;
            ST_SCAN:   w_ram_re        = r_raddr < r_n;
            ST_DIV_GO: w_div_start     = 1'b1;
            ST_SCL_GO: w_scl_start     = 1'b1;
            ST_DONE:   w_out_load      = !r_ovalid || i_m_axis_tready;
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_div_req = '{start: w_div_start, dx: r_dx, mag: r_mag, width: r_width};
    assign w_scl_req = '{start: w_scl_start, gain: r_gain, v: r_v};

    // loads beyond the table are dropped
    assign w_ram_we = w_s_xfer && (w_op == OP_LOAD) && (w_idx_ext < NW'(MAX_POINTS));

    pli_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata ({w_xin, w_yin}),
        .i_re    (w_ram_re),
        .i_raddr (r_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    pli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    pli_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_scl_req),
        .o_done   (w_scl_done),
        .o_result (w_scl_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= COUNT_RESET;
            r_gain   <= GAIN_RESET;
            r_rvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= w_ram_re;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_POINT_COUNT: r_count <= i_cfg_wdata[COUNT_W-1:0];
                    CFG_GAIN:        r_gain  <= i_cfg_wdata;
                    default:         r_count <= r_count;
                endcase
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_xq    <= w_xin;
            r_n     <= w_n_eff;
            r_raddr <= '0;
            r_res   <= '{saturated: 1'b0, in_range: 1'b0, value: MISS_VALUE};
        end
        if (w_ram_re) begin
            r_raddr <= r_raddr + NW'(1);
            r_ridx  <= r_raddr[AW-1:0];
        end
        if (r_rvalid) begin
            r_px <= w_cx;
            r_py <= w_cy;
        end
        if (w_hit) begin
            r_dx    <= w_xdiff[VAL_W-1:0];
            r_width <= w_wdiff[VAL_W-1:0];
            r_mag   <= w_dy_abs[VAL_W-1:0];
            r_neg   <= w_dy[VAL_W];
            r_y0    <= r_py;
        end
        if (w_div_done) begin
            r_v <= w_vsum[VAL_W-1:0];
        end
        if (w_scl_done) begin
            r_res <= w_scl_res;
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out.value;
    assign o_m_axis_tuser  = {r_out.saturated, r_out.in_range};

endmodule

@@ rtl/pli_ram.sv @@
// ----------------------------------------------------------------------------
// pli_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pli_muldiv.sv @@
// ----------------------------------------------------------------------------
// pli_muldiv
// Computes dx * mag / width, truncated; one multiply then a 32-step
// restoring division. The quotient is known to fit 32 bits since dx < width.
// ----------------------------------------------------------------------------
module pli_muldiv
    import pli_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [VAL_W-1:0] o_quot
);

    logic               r_busy;
    logic               r_done;
    logic [5:0]         r_cnt;
    logic [VAL_W-1:0]   r_rem;
    logic [VAL_W-1:0]   r_low;
    logic [VAL_W-1:0]   r_den;
    logic [2*VAL_W-1:0] w_prod;
    logic [VAL_W:0]     w_trial;
    logic [VAL_W:0]     w_diff;
    logic               w_qbit;

    assign w_prod  = i_req.dx * i_req.mag;
    assign w_trial = {r_rem, r_low[VAL_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_qbit  = ~w_diff[VAL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(VAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so 32 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= w_prod[2*VAL_W-1:VAL_W];
            r_low <= w_prod[VAL_W-1:0];
            r_den <= i_req.width;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[VAL_W-1:0] : w_trial[VAL_W-1:0];
            r_low <= {r_low[VAL_W-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

@@ rtl/pli_scale.sv @@
// ----------------------------------------------------------------------------
// pli_scale
// Multiplies the interpolated value by the gain, drops 16 fraction bits
// toward zero and saturates to 32 bits.
// ----------------------------------------------------------------------------
module pli_scale
    import pli_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scale_req i_req,
    output logic       o_done,
    output t_result    o_result
);

    logic                      r_stage;
    logic                      r_done;
    logic signed [2*VAL_W-1:0] r_p;
    t_result                   r_result;
    logic signed [VAL_W-1:0]   w_gain;
    logic signed [VAL_W-1:0]   w_v;
    logic signed [47:0]        w_sh;
    logic signed [47:0]        w_hi;
    logic                      w_pos_sat;
    logic                      w_neg_sat;

    assign w_gain = i_req.gain;
    assign w_v    = i_req.v;
    assign w_sh   = r_p[2*VAL_W-1:16];
    // arithmetic shift floors; bump negative values with a fraction back up
    assign w_hi   = (r_p[2*VAL_W-1] && (r_p[15:0] != 16'd0)) ? w_sh + 48'sd1 : w_sh;
    assign w_pos_sat = w_hi > 48'sh0000_7FFF_FFFF;
    assign w_neg_sat = w_hi < -48'sh0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_req.start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_p <= w_gain * w_v;
        end
        if (r_stage) begin
            r_result.in_range  <= 1'b1;
            r_result.saturated <= w_pos_sat | w_neg_sat;
            if (w_pos_sat) begin
                r_result.value <= 32'h7FFF_FFFF;
            end else if (w_neg_sat) begin
                r_result.value <= 32'h8000_0000;
            end else begin
                r_result.value <= w_hi[VAL_W-1:0];
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ tb/tb_scaled_piecewise_linear_interp.sv @@
// ----------------------------------------------------------------------------
// tb_scaled_piecewise_linear_interp
// Self-checking bench for the breakpoint interpolator: a directed table of
// loads, evaluations and register writes, then phases of random traffic over
// sorted, full-range and scrambled tables with varied gain and backpressure.
// Every evaluation is predicted in the bench and compared with the output.
// ----------------------------------------------------------------------------
module tb_scaled_piecewise_linear_interp;
    import pli_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    // longer than one evaluation over a full table
    localparam int DRAIN_CYCLES  = 400;
    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    typedef enum {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_e;
    typedef enum {TAB_SORTED, TAB_WIDE, TAB_SCRAMBLED} layout_e;
    typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [7:0]  sel;
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;
        t_result     res;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [71:0] s_data    = '0;
    logic        s_user    = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [31:0] m_data;
    logic [1:0]  m_user;

    // bench copy of the block state
    logic signed [31:0] bp_x [TABLE_DEPTH];
    logic signed [31:0] bp_y [TABLE_DEPTH];
    logic [8:0]         bp_count = COUNT_RESET;
    logic signed [31:0] bp_gain  = GAIN_RESET;

    t_result pending_results[$];
    int      mismatches     = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_req       = 0;
    int      hold_seen      = 0;
    int      hold_left      = 0;

    scaled_piecewise_linear_interp dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // first matching segment x0 <= x < x1, then scale and clip
    function automatic t_result interp_at(input logic signed [31:0] xq);
        t_result r;
        int n;
        longint x0, x1, y0, y1, dy, v, s;
        longint unsigned dx, w, mag, q;
        r.value     = MISS_VALUE;
        r.in_range  = 1'b0;
        r.saturated = 1'b0;
        n = (bp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(bp_count);
        for (int i = 1; i < n; i++) begin
            x0 = bp_x[i-1];
            x1 = bp_x[i];
            if (x0 <= xq && xq < x1) begin
                y0  = bp_y[i-1];
                y1  = bp_y[i];
                dx  = xq - x0;
                w   = x1 - x0;
                dy  = y1 - y0;
                mag = (dy < 0) ? -dy : dy;
                q   = dx * mag / w;
                v   = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
                s   = (longint'(bp_gain) * v) / 65536;
                r.in_range = 1'b1;
                if (s > SAT_HI) begin
                    s = SAT_HI;
                    r.saturated = 1'b1;
                end else if (s < SAT_LO) begin
                    s = SAT_LO;
                    r.saturated = 1'b1;
                end
                r.value = s[31:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic dir_row_t load_row(input logic [7:0] idx, input logic [31:0] x,
                                          input logic [31:0] y);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_LOAD;
        r.sel  = idx;
        r.a    = x;
        r.b    = y;
        return r;
    endfunction

    // index and y carry junk on evaluations, the block must ignore them
    function automatic dir_row_t eval_row(input logic [31:0] x);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_EVAL;
        r.sel  = 8'hA5;
        r.a    = x;
        r.b    = 32'h5A5A_A5A5;
        return r;
    endfunction

    function automatic dir_row_t known_row(input logic [31:0] x, input logic [31:0] value,
                                           input logic inr, input logic sat);
        dir_row_t r;
        r       = eval_row(x);
        r.typed = 1'b1;
        r.res   = {sat, inr, value};
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [0:0] addr, input logic [31:0] val);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.sel  = {7'b0, addr};
        r.a    = val;
        return r;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    task automatic set_pace(input pace_e p);
        case (p)
            PACE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            PACE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default:   begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input logic op, input logic [7:0] idx, input logic [31:0] xv,
                             input logic [31:0] yv, input logic typed, input t_result known);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {yv, xv, idx};
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
        if (op == OP_LOAD) begin
            bp_x[idx] = xv;
            bp_y[idx] = yv;
        end else begin
            pending_results.push_back(typed ? known : interp_at(xv));
        end
        @(negedge clk);
    endtask

    // loads leave no result behind, so give the last one time to land
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] addr, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == CFG_POINT_COUNT)
            bp_count = val[8:0];
        else
            bp_gain = val;
        @(negedge clk);
    endtask

    task automatic load_table(input layout_e lay, input int nload);
        longint      xs;
        logic [31:0] xv, yv, prev_x;
        int unsigned step_max;
        prev_x   = $urandom;
        xs       = -longint'($urandom_range(32'h4000_0000));
        step_max = 32'h0010_0000;
        if (lay == TAB_WIDE) begin
            xs       = -64'sd2147483648;
            step_max = (nload > 1) ? 32'hFFFF_FFFF / (nload - 1) : 0;
        end
        for (int k = 0; k < nload; k++) begin
            if (lay == TAB_SCRAMBLED) begin
                // repeated x gives zero-width segments
                xv = ($urandom_range(3) == 0) ? prev_x : $urandom;
            end else begin
                xv = (xs > SAT_HI) ? 32'h7FFF_FFFF : xs[31:0];
                if ($urandom_range(9) != 0)
                    xs = xs + longint'($urandom_range(step_max));
            end
            prev_x = xv;
            yv = $urandom_range(1) ? $urandom
                                   : 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
            send_item(OP_LOAD, 8'(k), xv, yv, 1'b0, '0);
        end
    endtask

    // mostly inside a segment, some on breakpoints, some anywhere
    function automatic logic [31:0] pick_query(input int n);
        int          i;
        longint      x0, w;
        int unsigned roll;
        roll = $urandom_range(99);
        if (n >= 2 && roll < 70) begin
            i  = $urandom_range(n - 1, 1);
            x0 = bp_x[i-1];
            w  = bp_x[i] - x0;
            if (w <= 0)
                return bp_x[i-1];
            return 32'(x0 + longint'($urandom_range(32'(w - 1))));
        end
        if (n >= 1 && roll < 85)
            return bp_x[$urandom_range(n - 1)];
        return $urandom;
    endfunction

    task automatic random_items(input int nitems);
        int         n;
        logic [7:0] idx;
        repeat (nitems) begin
            n = (bp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(bp_count);
            if ($urandom_range(99) < 12) begin
                idx = (n > 0 && $urandom_range(1)) ? 8'($urandom_range(n - 1))
                                                   : 8'($urandom_range(255));
                send_item(OP_LOAD, idx, $urandom, $urandom, 1'b0, '0);
            end else begin
                send_item(OP_EVAL, 8'($urandom), pick_query(n), $urandom, 1'b0, '0);
            end
        end
    endtask

    task automatic run_phase(input int count_val, input logic [31:0] gain_val,
                             input pace_e pace, input layout_e lay, input int nitems,
                             input logic hold);
        wait_idle();
        set_pace(pace);
        load_table(lay, (count_val > TABLE_DEPTH) ? TABLE_DEPTH : count_val);
        wait_idle();
        write_reg(CFG_POINT_COUNT, 32'(count_val));
        write_reg(CFG_GAIN, gain_val);
        // receiver holds off while items keep coming, so the input backs up
        if (hold)
            hold_req++;
        random_items(nitems);
    endtask

    always @(negedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_result got, want;
        if (rst_n && m_valid && m_ready) begin
            got = {m_user[1], m_user[0], m_data};
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result %h in_range %b saturated %b, none expected",
                                        got.value, got.in_range, got.saturated));
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.in_range !== want.in_range ||
                    got.saturated !== want.saturated)
                    note_mismatch($sformatf(
                        "result %h in_range %b saturated %b, expected %h %b %b",
                        got.value, got.in_range, got.saturated,
                        want.value, want.in_range, want.saturated));
            end
        end
    end

    initial begin
        dir_row_t rows[$];
        // empty table after reset
        rows.push_back(known_row(32'h0000_0000, MISS_VALUE, 1'b0, 1'b0));
        rows.push_back(load_row(8'd0, 32'h0000_0000, 32'h0000_0000));
        rows.push_back(load_row(8'd1, 32'h0001_0000, 32'h0002_0000));
        rows.push_back(reg_row(CFG_POINT_COUNT, 32'd1));
        // a single point has no segment
        rows.push_back(known_row(32'h0000_0000, MISS_VALUE, 1'b0, 1'b0));
        rows.push_back(reg_row(CFG_POINT_COUNT, 32'd2));
        rows.push_back(known_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0));
        rows.push_back(known_row(32'h0000_8000, 32'h0001_0000, 1'b1, 1'b0));
        // right end of a segment is excluded
        rows.push_back(known_row(32'h0001_0000, MISS_VALUE, 1'b0, 1'b0));
        rows.push_back(known_row(32'h8000_0000, MISS_VALUE, 1'b0, 1'b0));
        rows.push_back(known_row(32'h7FFF_FFFF, MISS_VALUE, 1'b0, 1'b0));
        // zero-width segment between points 1 and 2
        rows.push_back(load_row(8'd2, 32'h0001_0000, 32'h7FFF_FFFF));
        rows.push_back(load_row(8'd3, 32'h7FFF_FFFF, 32'h8000_0000));
        rows.push_back(reg_row(CFG_POINT_COUNT, 32'd4));
        rows.push_back(known_row(32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
        rows.push_back(eval_row(32'h7FFF_FFFE));
        rows.push_back(eval_row(32'h0000_4000));
        rows.push_back(reg_row(CFG_GAIN, 32'h7FFF_FFFF));
        rows.push_back(known_row(32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 1'b1));
        rows.push_back(reg_row(CFG_GAIN, 32'h8000_0000));
        rows.push_back(known_row(32'h0001_0000, 32'h8000_0000, 1'b1, 1'b1));
        rows.push_back(eval_row(32'h7FFF_FFFE));
        rows.push_back(known_row(32'h8000_0000, MISS_VALUE, 1'b0, 1'b0));
        rows.push_back(reg_row(CFG_GAIN, 32'h0000_0000));
        rows.push_back(known_row(32'h0000_8000, 32'h0000_0000, 1'b1, 1'b0));
        // one segment over the whole range, falling slope
        rows.push_back(load_row(8'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        rows.push_back(load_row(8'd1, 32'h7FFF_FFFF, 32'h8000_0000));
        rows.push_back(reg_row(CFG_POINT_COUNT, 32'd2));
        rows.push_back(reg_row(CFG_GAIN, 32'hFFFF_0000));
        rows.push_back(eval_row(32'h8000_0000));
        rows.push_back(eval_row(32'h0000_0000));
        rows.push_back(eval_row(32'h7FFF_FFFE));
        rows.push_back(load_row(8'd255, 32'h1234_5678, 32'h8765_4321));
        rows.push_back(reg_row(CFG_GAIN, 32'h0001_0000));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_pace(PACE_NONE);

        foreach (rows[k]) begin
            case (rows[k].kind)
                ROW_CFG: begin
                    wait_idle();
                    write_reg(rows[k].sel[0:0], rows[k].a);
                end
                ROW_LOAD: send_item(OP_LOAD, rows[k].sel, rows[k].a, rows[k].b, 1'b0, '0);
                default:  send_item(OP_EVAL, rows[k].sel, rows[k].a, rows[k].b,
                                    rows[k].typed, rows[k].res);
            endcase
        end

        run_phase(2,   32'h0001_0000, PACE_NONE, TAB_WIDE,      40, 1'b0);
        run_phase(8,   $urandom,      PACE_SEND, TAB_SORTED,    35, 1'b0);
        run_phase(16,  32'h7FFF_FFFF, PACE_RECV, TAB_WIDE,      35, 1'b0);
        run_phase(5,   32'h8000_0000, PACE_BOTH, TAB_SORTED,    35, 1'b0);
        // count beyond the table depth scans the whole table
        run_phase(300, 32'h0001_0000, PACE_NONE, TAB_SORTED,    40, 1'b1);
        run_phase(3,   32'hFFFF_0000, PACE_SEND, TAB_SCRAMBLED, 35, 1'b0);
        run_phase(0,   $urandom,      PACE_RECV, TAB_SORTED,    15, 1'b0);
        run_phase(1,   $urandom,      PACE_BOTH, TAB_SORTED,    15, 1'b0);
        run_phase(12,  32'h0000_8000, PACE_NONE, TAB_SORTED,    40, 1'b1);
        run_phase(6,   $urandom,      PACE_RECV, TAB_SCRAMBLED, 35, 1'b0);
        run_phase(4,   32'h0000_0000, PACE_SEND, TAB_WIDE,      35, 1'b0);
        run_phase(10,  $urandom,      PACE_BOTH, TAB_WIDE,      40, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/pli_muldiv.sv
rtl/pli_scale.sv
rtl/scaled_piecewise_linear_interp.sv
tb/tb_scaled_piecewise_linear_interp.sv
